/* design/fsmq_pkg.sv */
`timescale 1ns / 1ps

package fsmq_pkg;

	localparam int LEN_W     = 7;
	localparam int SLOT_W    = 8;
	localparam int OFF_W     = 6;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;
	localparam int Q_DEPTH   = 4;

	localparam logic [1:0] K_ADD    = 2'd0;
	localparam logic [1:0] K_REMOVE = 2'd1;
	localparam logic [1:0] K_FLUSH  = 2'd2;
	localparam logic [1:0] K_UNUSED = 2'd3;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_WOULD_BLOCK = 2'd1;
	localparam logic [1:0] ST_MUST_WAIT   = 2'd2;
	localparam logic [1:0] ST_TOO_LONG    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_SLOTS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BYTES = 1'b1;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] slot;
		logic [OFF_W-1:0]  off;
		logic [7:0]        data;
	} mem_wr_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] slot;
		logic [LEN_W-1:0]  len;
	} len_wr_t;

	// one queued job for the back end: a single result or a slot readout
	typedef struct packed {
		logic              is_remove;
		logic [1:0]        status;
		logic [SLOT_W-1:0] slot;
	} q_entry_t;

endpackage

/* design/fsmq_in_if.sv */
`timescale 1ns / 1ps

interface fsmq_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       zero_length;
	logic       no_wait;

	modport source (output valid, kind, data_byte, last_byte, zero_length, no_wait,
		input ready);
	modport sink (input valid, kind, data_byte, last_byte, zero_length, no_wait,
		output ready);
endinterface

/* design/fsmq_out_if.sv */
`timescale 1ns / 1ps

interface fsmq_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [7:0] out_byte;
	logic [6:0] out_length;
	logic       out_valid;
	logic       last_out;

	modport source (output valid, status, out_byte, out_length, out_valid, last_out,
		input ready);
	modport sink (input valid, status, out_byte, out_length, out_valid, last_out,
		output ready);
endinterface

/* design/fsmq_front.sv */
`timescale 1ns / 1ps

module fsmq_front #(
	parameter int SLOTS      = 16,
	parameter int SLOT_BYTES = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	fsmq_in_if.sink                         in_ch,
	input  logic                            cfg_we,
	input  logic [fsmq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fsmq_pkg::CFG_W-1:0]      cfg_data,
	output logic                            q_push,
	output fsmq_pkg::q_entry_t              q_data,
	input  logic                            q_full,
	output fsmq_pkg::mem_wr_t               mem_wr,
	output fsmq_pkg::len_wr_t               len_wr,
	input  logic                            remove_done
);
	import fsmq_pkg::*;

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	localparam logic [1:0] REF_NONE = 2'd0;
	localparam logic [1:0] REF_FULL = 2'd1;
	localparam logic [1:0] REF_LONG = 2'd2;

	logic [4:0]       slots_cfg_q;
	logic [LEN_W-1:0] bytes_cfg_q;
	logic [SW-1:0]    ws_q;
	logic [CW-1:0]    count_q;
	logic [LEN_W-1:0] fill_q;
	logic [1:0]       ref_q;
	logic             pending_q;

	logic [CW-1:0]    ns;
	logic [LEN_W-1:0] eb;
	logic [CW-1:0]    ws_ext;
	logic [CW-1:0]    ws_inc;
	logic [CW-1:0]    rs;
	logic [1:0]       ref_a;
	logic [LEN_W-1:0] fill_a;
	logic             store;
	logic [1:0]       add_st;
	logic [1:0]       wait_code;
	logic             accept;
	logic             is_add;
	logic             commit;

	assign in_ch.ready = !q_full && !pending_q;
	assign accept      = in_ch.valid && in_ch.ready;
	assign is_add      = (in_ch.kind == K_ADD);
	assign wait_code   = in_ch.no_wait ? ST_WOULD_BLOCK : ST_MUST_WAIT;

	always_comb begin
		if (slots_cfg_q == '0)
			ns = CW'(1);
		else if (32'(slots_cfg_q) > SLOTS)
			ns = CW'(SLOTS);
		else
			ns = CW'(slots_cfg_q);

		if (bytes_cfg_q == '0)
			eb = LEN_W'(1);
		else if (32'(bytes_cfg_q) > SLOT_BYTES)
			eb = LEN_W'(SLOT_BYTES);
		else
			eb = bytes_cfg_q;
	end

	assign ws_ext = CW'(ws_q);
	assign ws_inc = ws_ext + CW'(1);
	// oldest slot sits count entries behind the write slot, modulo the ring size
	assign rs = (ws_ext >= count_q) ? ws_ext - count_q : ns - count_q + ws_ext;

	always_comb begin
		ref_a = ref_q;
		store = 1'b0;
		if (fill_q == '0 && ref_q == REF_NONE && count_q >= ns)
			ref_a = REF_FULL;
		if (ref_a == REF_NONE && !(in_ch.last_byte && in_ch.zero_length)) begin
			if (fill_q >= eb)
				ref_a = REF_LONG;
			else
				store = 1'b1;
		end
		fill_a = fill_q + LEN_W'(store);
		if (ref_a == REF_FULL)
			add_st = wait_code;
		else if (ref_a == REF_LONG)
			add_st = ST_TOO_LONG;
		else
			add_st = ST_OK;
		commit = in_ch.last_byte && ref_a == REF_NONE;
	end

	always_comb begin
		q_push         = accept && in_ch.kind != K_UNUSED;
		q_data.slot    = SLOT_W'(rs);
		q_data.is_remove = 1'b0;
		unique case (in_ch.kind)
			K_ADD: q_data.status = add_st;
			K_REMOVE: begin
				q_data.is_remove = (count_q != '0);
				q_data.status    = (count_q == '0) ? wait_code : ST_OK;
			end
			default: q_data.status = ST_OK;
		endcase

		mem_wr.we   = accept && is_add && store;
		mem_wr.slot = SLOT_W'(ws_q);
		mem_wr.off  = OFF_W'(fill_q);
		mem_wr.data = in_ch.data_byte;

		len_wr.we   = accept && is_add && commit;
		len_wr.slot = SLOT_W'(ws_q);
		len_wr.len  = fill_a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_cfg_q <= 5'd16;
			bytes_cfg_q <= 7'd64;
			ws_q        <= '0;
			count_q     <= '0;
			fill_q      <= '0;
			ref_q       <= REF_NONE;
			pending_q   <= 1'b0;
		end else begin
			if (remove_done)
				pending_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_SLOTS: slots_cfg_q <= cfg_data[4:0];
					CFG_BYTES: bytes_cfg_q <= cfg_data;
					default: ;
				endcase
				ws_q    <= '0;
				count_q <= '0;
				fill_q  <= '0;
				ref_q   <= REF_NONE;
			end else if (accept) begin
				unique case (in_ch.kind)
					K_ADD: begin
						if (in_ch.last_byte) begin
							fill_q <= '0;
							ref_q  <= REF_NONE;
						end else begin
							fill_q <= fill_a;
							ref_q  <= ref_a;
						end
						if (commit) begin
							count_q <= count_q + CW'(1);
							ws_q    <= (ws_inc >= ns) ? '0 : SW'(ws_inc);
						end
					end
					K_REMOVE: begin
						if (count_q != '0) begin
							count_q   <= count_q - CW'(1);
							// hold off input until the slot has been read out
							pending_q <= 1'b1;
						end
					end
					K_FLUSH: begin
						ws_q    <= '0;
						count_q <= '0;
						fill_q  <= '0;
						ref_q   <= REF_NONE;
					end
					default: ;
				endcase
			end
		end
	end

endmodule

/* design/fsmq_queue.sv */
`timescale 1ns / 1ps

module fsmq_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  fsmq_pkg::q_entry_t push_data,
	output logic               full,
	output logic               head_valid,
	output fsmq_pkg::q_entry_t head,
	input  logic               pop
);
	import fsmq_pkg::*;

	localparam int PW = $clog2(Q_DEPTH);

	q_entry_t      entry_q [Q_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   used_q;

	logic do_push;
	logic do_pop;

	assign full       = (used_q == (PW + 1)'(Q_DEPTH));
	assign head_valid = (used_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			used_q   <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			used_q <= used_q + (PW + 1)'(do_push) - (PW + 1)'(do_pop);
		end
	end

endmodule

/* design/fsmq_back.sv */
`timescale 1ns / 1ps

module fsmq_back #(
	parameter int SLOTS      = 16,
	parameter int SLOT_BYTES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  fsmq_pkg::q_entry_t q_head,
	output logic               q_pop,
	input  fsmq_pkg::mem_wr_t  mem_wr,
	input  fsmq_pkg::len_wr_t  len_wr,
	fsmq_out_if.source         out_ch,
	output logic               remove_done
);
	import fsmq_pkg::*;

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int BW = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
	localparam int AW = SW + BW;

	typedef enum logic [1:0] {
		B_IDLE,
		B_LEN,
		B_STREAM
	} state_t;

	logic [7:0]       msg_mem [2**AW];
	logic [LEN_W-1:0] len_mem [2**SW];

	state_t           state_q;
	logic [SW-1:0]    rs_q;
	logic [LEN_W-1:0] len_q;
	logic [OFF_W-1:0] idx_q;
	logic [LEN_W-1:0] len_rdata_q;
	logic [7:0]       rdata_s1;
	logic             rd_v_s1;
	logic             last_s1;
	logic [LEN_W-1:0] len_s1;

	logic             out_v_q;
	logic [1:0]       status_q;
	logic [7:0]       byte_q;
	logic [LEN_W-1:0] length_q;
	logic             ov_q;
	logic             last_q;

	logic             out_free;
	logic             s1_move;
	logic             single_load;
	logic [1:0]       single_st;
	logic             len_rd_en;
	logic             rd_en;
	logic             is_last;

	assign out_free = !out_v_q || out_ch.ready;
	assign s1_move  = rd_v_s1 && out_free;
	assign is_last  = (LEN_W'(idx_q) + LEN_W'(1) == len_q);

	always_comb begin
		q_pop       = 1'b0;
		single_load = 1'b0;
		single_st   = ST_OK;
		len_rd_en   = 1'b0;
		rd_en       = 1'b0;
		remove_done = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					if (q_head.is_remove) begin
						len_rd_en = 1'b1;
						q_pop     = 1'b1;
					end else if (out_free && !rd_v_s1) begin
						// single results wait until the previous stream has drained
						single_load = 1'b1;
						single_st   = q_head.status;
						q_pop       = 1'b1;
					end
				end
			end
			B_LEN: begin
				if (len_rdata_q == '0 && out_free && !rd_v_s1) begin
					single_load = 1'b1;
					remove_done = 1'b1;
				end
			end
			B_STREAM: begin
				rd_en = !rd_v_s1 || out_free;
				remove_done = rd_en && is_last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_wr.we)
			msg_mem[{mem_wr.slot[SW-1:0], mem_wr.off[BW-1:0]}] <= mem_wr.data;
		if (rd_en)
			rdata_s1 <= msg_mem[{rs_q, idx_q[BW-1:0]}];
	end

	always_ff @(posedge clk) begin
		if (len_wr.we)
			len_mem[len_wr.slot[SW-1:0]] <= len_wr.len;
		if (len_rd_en)
			len_rdata_q <= len_mem[q_head.slot[SW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			rs_q     <= '0;
			len_q    <= '0;
			idx_q    <= '0;
			rd_v_s1  <= 1'b0;
			last_s1  <= 1'b0;
			len_s1   <= '0;
			out_v_q  <= 1'b0;
			status_q <= ST_OK;
			byte_q   <= '0;
			length_q <= '0;
			ov_q     <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (len_rd_en) begin
						rs_q    <= q_head.slot[SW-1:0];
						state_q <= B_LEN;
					end
				end
				B_LEN: begin
					if (len_rdata_q == '0) begin
						if (single_load)
							state_q <= B_IDLE;
					end else begin
						len_q   <= len_rdata_q;
						idx_q   <= '0;
						state_q <= B_STREAM;
					end
				end
				B_STREAM: begin
					if (rd_en) begin
						idx_q   <= idx_q + OFF_W'(1);
						last_s1 <= is_last;
						len_s1  <= len_q;
						if (is_last)
							state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase

			if (rd_en)
				rd_v_s1 <= 1'b1;
			else if (s1_move)
				rd_v_s1 <= 1'b0;

			if (s1_move) begin
				out_v_q  <= 1'b1;
				status_q <= ST_OK;
				byte_q   <= rdata_s1;
				length_q <= len_s1;
				ov_q     <= 1'b1;
				last_q   <= last_s1;
			end else if (single_load) begin
				out_v_q  <= 1'b1;
				status_q <= single_st;
				byte_q   <= '0;
				length_q <= '0;
				ov_q     <= 1'b0;
				last_q   <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid      = out_v_q;
	assign out_ch.status     = status_q;
	assign out_ch.out_byte   = byte_q;
	assign out_ch.out_length = length_q;
	assign out_ch.out_valid  = ov_q;
	assign out_ch.last_out   = last_q;

`ifndef SYNTH
	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(single_load && s1_move))
		else $error("stream byte and single result loaded together");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_STREAM) |-> (LEN_W'(idx_q) < len_q))
		else $error("read index beyond stored length");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		remove_done |=> (state_q == B_IDLE))
		else $error("readout finished but back end not idle");
`endif

endmodule

/* design/fixed_slot_message_queue.sv */
`timescale 1ns / 1ps

// Ring of SLOTS message slots of up to SLOT_BYTES bytes each. Byte adds and
// flushes are taken one per cycle while the job queue has room and no remove is
// pending, and each answers one result; they pass a four-entry job queue to the
// back end, so input keeps flowing while a result waits on the output register.
// A remove of a stored n-byte message reads its length from the length memory,
// then streams n results from the two-port message memory, one per cycle unless
// the output stalls; input is held off after the remove until the last byte
// read is issued. A config write empties the ring and aborts a partial add.
module fixed_slot_message_queue #(
	parameter int SLOTS      = 16,
	parameter int SLOT_BYTES = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	fsmq_in_if.sink                         in_ch,
	fsmq_out_if.source                      out_ch,
	input  logic                            cfg_we,
	input  logic [fsmq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fsmq_pkg::CFG_W-1:0]      cfg_data
);
	import fsmq_pkg::*;

	q_entry_t q_in;
	q_entry_t q_head;
	logic     q_push;
	logic     q_pop;
	logic     q_full;
	logic     q_valid;
	mem_wr_t  mem_wr;
	len_wr_t  len_wr;
	logic     remove_done;

	fsmq_front #(
		.SLOTS      (SLOTS),
		.SLOT_BYTES (SLOT_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_push      (q_push),
		.q_data      (q_in),
		.q_full      (q_full),
		.mem_wr      (mem_wr),
		.len_wr      (len_wr),
		.remove_done (remove_done)
	);

	fsmq_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_in),
		.full       (q_full),
		.head_valid (q_valid),
		.head       (q_head),
		.pop        (q_pop)
	);

	fsmq_back #(
		.SLOTS      (SLOTS),
		.SLOT_BYTES (SLOT_BYTES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.mem_wr      (mem_wr),
		.len_wr      (len_wr),
		.out_ch      (out_ch),
		.remove_done (remove_done)
	);

endmodule
